/* rtl/sbl_pkg.sv */
// package for the stereo biquad lowpass unit
// holds widths, register indexes, coefficient reset values and the config type
// no dependencies
`default_nettype none

package sbl_pkg;

  localparam int unsigned COEF_W             = 32;
  localparam int unsigned DEF_SAMPLE_BITS    = 24;
  localparam int unsigned DEF_COEF_FRAC_BITS = 30;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STEREO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd5;

  localparam logic signed [COEF_W-1:0] B0_RST = 32'sd835106;
  localparam logic signed [COEF_W-1:0] B1_RST = 32'sd1670213;
  localparam logic signed [COEF_W-1:0] B2_RST = 32'sd835106;
  localparam logic signed [COEF_W-1:0] A1_RST = -32'sd2054192545;
  localparam logic signed [COEF_W-1:0] A2_RST = 32'sd983791147;

  typedef struct packed {
    logic                     stereo;
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/stereo_biquad_lowpass_unit.sv */
// an accepted request passes the work queue, the multiply stage register and the
// result queue; throughput: one request per cycle in stereo when the result queue
// has room, one at a time in mono; the per-channel history loop through the
// multiply stage and the sum sets it; reset: histories and channel toggle cleared,
// lowpass reset coefficients, stereo mode on, all queues empty; no clearing pass
// top level; depends on sbl_pkg, sbl_fifo, sbl_front, sbl_back
`default_nettype none

module stereo_biquad_lowpass_unit
  import sbl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [SAMPLE_BITS-1:0] sample_in_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic      [SAMPLE_BITS-1:0] sample_out_o,
  output logic                        was_right_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [COEF_W-1:0]      cfg_data_i
);

  cfg_t cfg_q, cfg_d;

  logic                 fq_push, fq_full, fq_pop, fq_empty;
  logic [SAMPLE_BITS:0] fq_wdata, fq_rdata;
  logic                 oq_push, oq_full;
  logic [SAMPLE_BITS:0] oq_wdata, oq_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STEREO: cfg_d.stereo = cfg_data_i[0];
        REG_B0:     cfg_d.b0     = $signed(cfg_data_i);
        REG_B1:     cfg_d.b1     = $signed(cfg_data_i);
        REG_B2:     cfg_d.b2     = $signed(cfg_data_i);
        REG_A1:     cfg_d.a1     = $signed(cfg_data_i);
        REG_A2:     cfg_d.a2     = $signed(cfg_data_i);
        default:    cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stereo <= 1'b1;
      cfg_q.b0     <= B0_RST;
      cfg_q.b1     <= B1_RST;
      cfg_q.b2     <= B2_RST;
      cfg_q.a1     <= A1_RST;
      cfg_q.a2     <= A2_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sbl_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .sample_i    (sample_in_i),
    .stereo_i    (cfg_q.stereo),
    .queue_full_i(fq_full),
    .queue_push_o(fq_push),
    .queue_data_o(fq_wdata)
  );

  assign full = fq_full;

  sbl_fifo #(
    .WIDTH(SAMPLE_BITS + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_work_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fq_push),
    .data_i (fq_wdata),
    .full_o (fq_full),
    .pop_i  (fq_pop),
    .data_o (fq_rdata),
    .empty_o(fq_empty)
  );

  sbl_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_valid_i(!fq_empty),
    .head_data_i (fq_rdata),
    .head_pop_o  (fq_pop),
    .out_full_i  (oq_full),
    .out_push_o  (oq_push),
    .out_data_o  (oq_wdata)
  );

  sbl_fifo #(
    .WIDTH(SAMPLE_BITS + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (oq_push),
    .data_i (oq_wdata),
    .full_o (oq_full),
    .pop_i  (pop),
    .data_o (oq_rdata),
    .empty_o(empty)
  );

  assign sample_out_o = oq_rdata[SAMPLE_BITS-1:0];
  assign was_right_o  = oq_rdata[SAMPLE_BITS];

endmodule

`default_nettype wire

/* rtl/sbl_fifo.sv */
// small register queue used between front, back and the result port
// depends on nothing
`default_nettype none

module sbl_fifo #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/sbl_front.sv */
// front part: takes input requests and tags each with its channel
// depends on sbl_pkg
`default_nettype none

module sbl_front
  import sbl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                   stereo_i,
  input  wire logic                   queue_full_i,
  output logic                        queue_push_o,
  output logic      [SAMPLE_BITS:0]   queue_data_o
);

  logic tog_q, tog_d;
  logic accept;
  logic ch;

  assign accept       = push_i && !queue_full_i;
  assign ch           = stereo_i && tog_q;
  assign queue_push_o = accept;
  assign queue_data_o = {ch, sample_i};

  always_comb begin
    tog_d = tog_q;
    if (accept) begin
      tog_d = stereo_i ? !tog_q : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tog_q <= 1'b0;
    end else begin
      tog_q <= tog_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_mono_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !stereo_i |-> !queue_data_o[SAMPLE_BITS])
    else $error("mono request tagged right");
  a_stereo_alt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && stereo_i |=> tog_q != $past(tog_q))
    else $error("stereo toggle did not flip");
  a_mono_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !stereo_i |=> !tog_q)
    else $error("toggle not held left in mono");
`endif

endmodule

`default_nettype wire

/* rtl/sbl_back.sv */
// back part: multiply stage, then sum, round, saturate and history update
// depends on sbl_pkg
`default_nettype none

module sbl_back
  import sbl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 head_valid_i,
  input  wire logic [SAMPLE_BITS:0] head_data_i,
  output logic                      head_pop_o,
  input  wire logic                 out_full_i,
  output logic                      out_push_o,
  output logic      [SAMPLE_BITS:0] out_data_o
);

  localparam int unsigned MUL_W  = COEF_W + SAMPLE_BITS;
  localparam int unsigned PROD_W = MUL_W + 1;
  localparam int unsigned ACC_W  = PROD_W + 3;
  localparam int unsigned QW     = ACC_W - COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [SAMPLE_BITS-1:0] xd1_q [2];
  logic signed [SAMPLE_BITS-1:0] xd2_q [2];
  logic signed [SAMPLE_BITS-1:0] yd1_q [2];
  logic signed [SAMPLE_BITS-1:0] yd2_q [2];

  logic                          s1_valid_q, s1_valid_d;
  logic                          s1_ch_q;
  logic signed [SAMPLE_BITS-1:0] s1_x_q;
  logic signed [PROD_W-1:0]      prod_q [5];
  logic signed [PROD_W-1:0]      prod_d [5];

  logic signed [SAMPLE_BITS-1:0] head_x;
  logic                          head_ch;
  logic signed [MUL_W-1:0]       m_b0, m_b1, m_b2, m_a1, m_a2;
  logic                          done, hazard, issue;
  logic signed [ACC_W-1:0]       acc, rnd;
  logic        [QW-1:0]          q;
  logic                          ovf;
  logic        [SAMPLE_BITS-1:0] y_sat;

  assign head_x  = $signed(head_data_i[SAMPLE_BITS-1:0]);
  assign head_ch = head_data_i[SAMPLE_BITS];

  // same-channel history is written only when the issued request leaves the multiply stage
  assign done   = s1_valid_q && !out_full_i;
  assign hazard = s1_valid_q && (s1_ch_q == head_ch);
  assign issue  = head_valid_i && (!s1_valid_q || done) && !hazard;

  assign head_pop_o = issue;

  assign m_b0 = cfg_i.b0 * head_x;
  assign m_b1 = cfg_i.b1 * xd1_q[head_ch];
  assign m_b2 = cfg_i.b2 * xd2_q[head_ch];
  assign m_a1 = cfg_i.a1 * yd1_q[head_ch];
  assign m_a2 = cfg_i.a2 * yd2_q[head_ch];

  always_comb begin
    prod_d[0] = PROD_W'(m_b0);
    prod_d[1] = PROD_W'(m_b1);
    prod_d[2] = PROD_W'(m_b2);
    prod_d[3] = -PROD_W'(m_a1);
    prod_d[4] = -PROD_W'(m_a2);
  end

  assign acc = ACC_W'(prod_q[0]) + ACC_W'(prod_q[1]) + ACC_W'(prod_q[2])
             + ACC_W'(prod_q[3]) + ACC_W'(prod_q[4]);
  assign rnd = acc + HALF;
  assign q   = rnd[ACC_W-1:COEF_FRAC_BITS];
  assign ovf = !((&q[QW-1:SAMPLE_BITS-1]) || !(|q[QW-1:SAMPLE_BITS-1]));
  assign y_sat = ovf ? {q[QW-1], {(SAMPLE_BITS-1){~q[QW-1]}}} : q[SAMPLE_BITS-1:0];

  assign out_push_o = done;
  assign out_data_o = {s1_ch_q, y_sat};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (issue) begin
      s1_valid_d = 1'b1;
    end else if (done) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        xd1_q[i] <= '0;
        xd2_q[i] <= '0;
        yd1_q[i] <= '0;
        yd2_q[i] <= '0;
      end
    end else begin
      s1_valid_q <= s1_valid_d;
      if (done) begin
        xd2_q[s1_ch_q] <= xd1_q[s1_ch_q];
        xd1_q[s1_ch_q] <= s1_x_q;
        yd2_q[s1_ch_q] <= yd1_q[s1_ch_q];
        yd1_q[s1_ch_q] <= $signed(y_sat);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_ch_q <= head_ch;
      s1_x_q  <= head_x;
      for (int i = 0; i < 5; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_y_hist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> yd1_q[$past(s1_ch_q)] == $signed($past(y_sat)))
    else $error("output history not updated");
  a_x_hist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> xd1_q[$past(s1_ch_q)] == $past(s1_x_q))
    else $error("input history not updated");
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !done |=> s1_valid_q && $stable(s1_ch_q) && $stable(s1_x_q))
    else $error("stalled stage lost its request");
`endif

endmodule

`default_nettype wire

/* tb/sv/sbl_scoreboard_pkg.sv */
// scoreboard for the stereo biquad lowpass unit testbench: a bit-exact direct form I
// filter with its own register copy and per-channel history, plus the result check
// depends on sbl_pkg
`timescale 1ns / 100ps

package sbl_scoreboard_pkg;

  import sbl_pkg::*;

  localparam int unsigned SW = DEF_SAMPLE_BITS;
  localparam int unsigned FW = DEF_COEF_FRAC_BITS;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          right;
  } filtered_t;

  class lowpass_scoreboard;
    cfg_t        regs_q;
    longint      x_d1[2];
    longint      x_d2[2];
    longint      y_d1[2];
    longint      y_d2[2];
    bit          next_right;
    filtered_t   filtered_q[$];
    int unsigned errors;
    int unsigned n_requests;
    int unsigned n_checked;
    int unsigned n_right;
    int unsigned n_clamped;

    function new();
      regs_q.stereo = 1'b1;
      regs_q.b0     = 32'sd835106;
      regs_q.b1     = 32'sd1670213;
      regs_q.b2     = 32'sd835106;
      regs_q.a1     = -32'sd2054192545;
      regs_q.a2     = 32'sd983791147;
      for (int c = 0; c < 2; c++) begin
        x_d1[c] = 0;
        x_d2[c] = 0;
        y_d1[c] = 0;
        y_d2[c] = 0;
      end
      next_right = 1'b0;
      errors     = 0;
      n_requests = 0;
      n_checked  = 0;
      n_right    = 0;
      n_clamped  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
        REG_STEREO: regs_q.stereo = data[0];
        REG_B0:     regs_q.b0 = data;
        REG_B1:     regs_q.b1 = data;
        REG_B2:     regs_q.b2 = data;
        REG_A1:     regs_q.a1 = data;
        REG_A2:     regs_q.a2 = data;
        default: ;
      endcase
    endfunction

    function void fail(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endfunction

    function void note_sample(logic [SW-1:0] raw);
      longint    x;
      longint    acc;
      longint    y;
      int        ch;
      filtered_t res;
      x   = longint'($signed(raw));
      ch  = regs_q.stereo ? int'(next_right) : 0;
      acc = longint'($signed(regs_q.b0)) * x
          + longint'($signed(regs_q.b1)) * x_d1[ch]
          + longint'($signed(regs_q.b2)) * x_d2[ch]
          - longint'($signed(regs_q.a1)) * y_d1[ch]
          - longint'($signed(regs_q.a2)) * y_d2[ch];
      // round half up, then clamp
      y = (acc + (longint'(1) <<< (FW - 1))) >>> FW;
      if (y > SAMPLE_MAX) begin
        y = SAMPLE_MAX;
        n_clamped++;
      end else if (y < SAMPLE_MIN) begin
        y = SAMPLE_MIN;
        n_clamped++;
      end
      x_d2[ch]   = x_d1[ch];
      x_d1[ch]   = x;
      y_d2[ch]   = y_d1[ch];
      y_d1[ch]   = y;
      next_right = regs_q.stereo ? ~next_right : 1'b0;
      res.sample = y[SW-1:0];
      res.right  = (ch == 1);
      filtered_q.push_back(res);
      n_requests++;
    endfunction

    function void check_result(logic [SW-1:0] got_sample, logic got_right);
      filtered_t want;
      if (filtered_q.size() == 0) begin
        fail($sformatf("result %0d (right %b) with no request outstanding",
                       $signed(got_sample), got_right));
        return;
      end
      want = filtered_q.pop_front();
      n_checked++;
      if (want.right) n_right++;
      if (got_sample !== want.sample) begin
        fail($sformatf("sample_out expected %0d actual %0d", $signed(want.sample),
                       $signed(got_sample)));
      end
      if (got_right !== want.right) begin
        fail($sformatf("was_right expected %b actual %b", want.right, got_right));
      end
    endfunction

    function int unsigned pending();
      return filtered_q.size();
    endfunction
  endclass

endpackage

/* tb/sv/stereo_biquad_lowpass_unit_tb.sv */
// top testbench for stereo_biquad_lowpass_unit: directed edge cases, then random
// samples under several coefficient sets, modes and push/pop throttling
// depends on sbl_pkg, sbl_scoreboard_pkg and the unit's rtl
`timescale 1ns / 100ps

module stereo_biquad_lowpass_unit_tb;

  import sbl_pkg::*;
  import sbl_scoreboard_pkg::*;

  localparam int unsigned LIMIT       = 200000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 158;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] COEF_REGS[5] = '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};

  localparam logic [COEF_W-1:0] UNITY    = 32'h4000_0000;
  localparam logic [COEF_W-1:0] HALF     = 32'h2000_0000;
  localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;
  localparam logic signed [COEF_W-1:0] LOWPASS[5] = '{32'sd835106, 32'sd1670213,
    32'sd835106, -32'sd2054192545, 32'sd983791147};

  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};

  logic                 clk_i;
  logic                 rst_ni    = 1'b0;
  logic                 push      = 1'b0;
  logic                 pop       = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [SW-1:0]        sample_in = '0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data  = '0;
  wire                  full;
  wire                  empty;
  wire                  was_right;
  wire                  cfg_ready;
  wire  [SW-1:0]        sample_out;

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned cycle_count = 0;

  lowpass_scoreboard sb = new();

  stereo_biquad_lowpass_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .sample_in_i  (sample_in),
    .empty        (empty),
    .pop          (pop),
    .sample_out_o (sample_out),
    .was_right_o  (was_right),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
    $display("stereo_biquad_lowpass_unit_tb: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!empty && pop) sb.check_result(sample_out, was_right);
      if (push && !full) sb.note_sample(sample_in);
    end
  end

  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                           input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                           input logic [COEF_W-1:0] a2);
    logic [COEF_W-1:0] vals[5];
    vals = '{b0, b1, b2, a1, a2};
    for (int i = 0; i < 5; i++) write_reg(COEF_REGS[i], vals[i]);
  endtask

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_sample(input logic [SW-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    sample_in <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [SW-1:0] rand_sample();
    logic [SW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = SW'($urandom);
      5, 6, 7:       v = SW'($urandom_range(8191)) - SW'(4096);
      default: begin
        case ($urandom_range(4))
          0:       v = S_MAX;
          1:       v = S_MIN;
          2:       v = '0;
          3:       v = '1;
          default: v = SW'(1);
        endcase
      end
    endcase
    return v;
  endfunction

  // 1: anything, 2: small and stable, 3: extremes
  function automatic logic [COEF_W-1:0] rand_coef(input int kind, input int idx);
    logic [COEF_W-1:0] r;
    r = $urandom;
    case (kind)
      0: return LOWPASS[idx];
      1: return r;
      2: return {{4{r[27]}}, r[27:0]};
      default: begin
        case ($urandom_range(4))
          0:       return COEF_MAX;
          1:       return COEF_MIN;
          2:       return '0;
          3:       return UNITY;
          default: return 32'hC000_0000;
        endcase
      end
    endcase
  endfunction

  task automatic load_config(input int kind, input bit stereo);
    logic [COEF_W-1:0] mode_word;
    mode_word    = $urandom;
    mode_word[0] = stereo;
    write_reg(REG_STEREO, mode_word);
    set_coefs(rand_coef(kind, 0), rand_coef(kind, 1), rand_coef(kind, 2),
              rand_coef(kind, 3), rand_coef(kind, 4));
    if ($urandom_range(1)) write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset lowpass, odd count leaves the toggle on the right channel
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample('0);
    send_sample(SW'(1));
    send_sample('1);
    settle();

    // spare indexes ignored, mode rewrite keeps the toggle
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h5A5A_A5A5);
    write_reg(REG_STEREO, 32'hFFFF_FFFF);
    set_coefs(UNITY, '0, '0, '0, '0);
    send_sample(S_MAX);
    send_sample(S_MIN);
    settle();

    // half-way rounding
    set_coefs(HALF, '0, '0, '0, '0);
    send_sample(SW'(1));
    send_sample('1);
    send_sample(SW'(3));
    send_sample(-SW'(3));
    settle();

    // clamping both ways
    set_coefs(COEF_MAX, '0, '0, '0, '0);
    send_sample(S_MAX);
    send_sample(S_MIN);
    settle();
    set_coefs(COEF_MIN, '0, '0, '0, '0);
    send_sample(S_MIN);
    send_sample(S_MAX);
    settle();

    // mono with feedback running into the clamp
    write_reg(REG_STEREO, 32'hFFFF_FFFE);
    set_coefs(UNITY, '0, '0, COEF_MIN, '0);
    send_sample(24'h40_0000);
    send_sample('0);
    send_sample('0);
    send_sample('0);
    settle();

    // back to stereo, starts on the left
    write_reg(REG_STEREO, 32'h0000_0001);
    set_coefs(LOWPASS[0], LOWPASS[1], LOWPASS[2], LOWPASS[3], LOWPASS[4]);
    send_sample(S_MAX);
    send_sample(S_MAX);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      load_config(p < 4 ? p : int'($urandom_range(3)), $urandom_range(9) < 7);
      repeat (PHASE_ITEMS) send_sample(rand_sample());
      settle();
    end

    $display("run covered %0d samples over %0d random phases plus directed cases",
             sb.n_requests, PHASES);
    $display("%0d results checked, %0d on the right channel, %0d clamped",
             sb.n_checked, sb.n_right, sb.n_clamped);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("stereo_biquad_lowpass_unit_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("stereo_biquad_lowpass_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
